// File: sv/arpr_pkg.sv
// arpr_pkg: shared types, codes and sizes of the arp resolver
// used by every module of the block, depends on nothing

package arpr_pkg;

	localparam int CACHE_ENTRIES   = 16;
	localparam int REQUEST_ENTRIES = 16;
	localparam int PENDING_DEPTH   = 16;
	localparam int MAX_FLUSH       = 16;

	localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RIDX_W = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
	localparam int SIDX_W = (CIDX_W > RIDX_W) ? CIDX_W : RIDX_W;
	localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
	localparam int SENT_W = $clog2(MAX_FLUSH + 1);

	localparam logic [1:0] FN_SEND = 2'd0;
	localparam logic [1:0] FN_RECV = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	localparam logic [2:0] KIND_IPV4    = 3'd0;
	localparam logic [2:0] KIND_ARP_REQ = 3'd1;
	localparam logic [2:0] KIND_ARP_REP = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_DROP    = 3'd4;

	localparam logic [15:0] ETH_IPV4   = 16'h0800;
	localparam logic [15:0] ETH_ARP    = 16'h0806;
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
	localparam logic [1:0] CFG_OWN_IP   = 2'd1;
	localparam logic [1:0] CFG_HOLDOFF  = 2'd2;
	localparam logic [1:0] CFG_LIFETIME = 2'd3;

	localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;
	localparam logic [19:0] CACHE_AGE_MAX  = 20'hF_FFFF;
	localparam logic [19:0] REQ_AGE_MAX    = 20'h1_FFFF;
	localparam logic [15:0] HOLDOFF_RESET  = 16'(5 * 1000);
	localparam logic [19:0] LIFETIME_RESET = 20'(30 * 1000);

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] hop_ip;
		logic [7:0]  datagram_tag;
		logic [47:0] frame_dst_mac;
		logic [47:0] frame_src_mac;
		logic [15:0] frame_type;
		logic [15:0] arp_opcode;
		logic [31:0] arp_sender_ip;
		logic [31:0] arp_target_ip;
		logic        arp_parse_ok;
		logic        ip_parse_ok;
		logic [15:0] elapsed_ms;
	} arpr_in_t;

	typedef struct packed {
		logic [2:0]  out_kind;
		logic [47:0] out_dst_mac;
		logic [31:0] out_target_ip;
		logic [7:0]  out_tag;
		logic        last;
	} arpr_out_t;

	typedef struct packed {
		logic        tick;
		logic [15:0] elapsed;
		logic [19:0] age_max;
		logic [19:0] limit;
		logic        expire_valid;
	} arpr_tick_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic        flag;
		logic        keep;
	} arpr_ewr_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [7:0]  tag;
	} arpr_pend_t;

endpackage

// File: sv/arpr_entry_cell.sv
// arpr_entry_cell: one cache or request table entry with its own ager
// depends on arpr_pkg

module arpr_entry_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  arpr_pkg::arpr_tick_t tick,
	input  logic                we,
	input  arpr_pkg::arpr_ewr_t wr,
	input  logic [31:0]         key,
	output logic                match,
	output logic                valid,
	output logic                flag,
	output logic [19:0]         age,
	output logic [47:0]         mac
);
	import arpr_pkg::*;

	logic        valid_q;
	logic        flag_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [19:0] age_q;
	logic [20:0] sum;
	logic [19:0] aged;
	logic        expired;

	assign sum     = {1'b0, age_q} + {5'b0, tick.elapsed};
	assign aged    = (sum > {1'b0, tick.age_max}) ? tick.age_max : sum[19:0];
	assign expired = aged >= tick.limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
		end else if (we) begin
			valid_q <= 1'b1;
			flag_q  <= wr.keep ? flag_q : wr.flag;
		end else if (tick.tick && valid_q && expired) begin
			if (tick.expire_valid) begin
				valid_q <= 1'b0;
			end else begin
				flag_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ip_q  <= wr.ip;
			mac_q <= wr.mac;
			age_q <= '0;
		end else if (tick.tick && valid_q) begin
			age_q <= aged;
		end
	end

	assign match = valid_q && (ip_q == key);
	assign valid = valid_q;
	assign flag  = flag_q;
	assign age   = age_q;
	assign mac   = mac_q;

endmodule

// File: sv/arpr_pend_cell.sv
// arpr_pend_cell: one slot of the pending queue, shifts toward the head
// depends on arpr_pkg

module arpr_pend_cell (
	input  logic                clk,
	input  logic                shift,
	input  arpr_pkg::arpr_pend_t next,
	input  logic                load,
	input  arpr_pkg::arpr_pend_t load_data,
	output arpr_pkg::arpr_pend_t data
);
	import arpr_pkg::*;

	arpr_pend_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next;
		end
	end

	assign data = data_q;

endmodule

// File: sv/arp_resolver_with_pending_queue.sv
// arp_resolver_with_pending_queue: arp cache, request table and pending queue
// depends on arpr_pkg, arpr_entry_cell, arpr_pend_cell
//
// usage: drive item and raise start while busy is low; the transfer happens at
// that edge and busy stays high while the item is processed.
// func send looks up the next hop, func recv handles one received frame and
// func tick ages every entry of both tables together.
// results come one per cycle at most on result, marked by result_strobe for
// one cycle; result.last marks the final one. the receiver cannot stall.
// each result is held until the next one is formed; the last one is on the
// ports in the first cycle after busy falls, when the next item may transfer.
// busy also covers the scan of a full table for its oldest entry and, when an
// arp reply arrives, the flush of the pending queue: the flush rotates the
// queue of cells one slot per cycle. with all tables at 16 entries the worst
// item is a reply that evicts a cache entry and flushes 16 datagrams.
// configuration is written through cfg_we, cfg_idx and cfg_data while idle.
// reset clears all tables, the queue and the configuration to its defaults;
// the block is ready in the first cycle after reset.

module arp_resolver_with_pending_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  arpr_pkg::arpr_in_t  item,
	output logic               result_strobe,
	output arpr_pkg::arpr_out_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [47:0]        cfg_data
);
	import arpr_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DECODE   = 9'b000000010,
		S_SEND_Q   = 9'b000000100,
		S_SEND_REQ = 9'b000001000,
		S_LEARNED  = 9'b000010000,
		S_SCAN     = 9'b000100000,
		S_ALLOC    = 9'b001000000,
		S_FLUSH    = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [15:0] holdoff_q;
	logic [19:0] lifetime_q;

	arpr_in_t    item_q;
	logic [31:0] key_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SENT_W-1:0] sent_q;

	logic [SIDX_W-1:0] scan_idx_q;
	logic [SIDX_W-1:0] best_q;
	logic [19:0]       best_age_q;
	logic              scan_cache_q;
	logic              scan_send_q;

	arpr_out_t held_q;
	logic      held_v_q;
	arpr_out_t result_q;
	logic      strobe_q;

	// cell side
	arpr_tick_t c_tick, r_tick;
	arpr_ewr_t  c_wr, r_wr;
	logic [CACHE_ENTRIES-1:0]   c_we, c_match, c_valid, c_flag;
	logic [REQUEST_ENTRIES-1:0] r_we, r_match, r_valid, r_flag;
	logic [19:0] c_age [CACHE_ENTRIES];
	logic [47:0] c_mac [CACHE_ENTRIES];
	logic [19:0] r_age [REQUEST_ENTRIES];
	logic [47:0] r_mac [REQUEST_ENTRIES];

	arpr_pend_t pend [PENDING_DEPTH];
	logic [PENDING_DEPTH-1:0] pend_load;
	arpr_pend_t pend_new;

	// lookups
	logic              chit_any, cfree_any, rhit_any, rfree_any;
	logic [CIDX_W-1:0] chit_idx, cfree_idx;
	logic [RIDX_W-1:0] rhit_idx, rfree_idx;

	// control
	logic      emit_v;
	arpr_out_t emit_r;
	logic      tick_go;
	logic      push;
	logic      shift;
	logic      keep_ld;
	logic      flush_drop;
	logic      flush_init;
	logic      scan_start;
	logic      scan_cache_d;
	logic      scan_send_d;
	logic      for_us;
	logic [19:0] scan_age;
	logic [SIDX_W-1:0] scan_last;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		chit_any  = 1'b0;
		chit_idx  = '0;
		cfree_any = 1'b0;
		cfree_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (c_match[i]) begin
				chit_any = 1'b1;
				chit_idx = CIDX_W'(i);
			end
			if (!c_valid[i]) begin
				cfree_any = 1'b1;
				cfree_idx = CIDX_W'(i);
			end
		end
	end

	always_comb begin
		rhit_any  = 1'b0;
		rhit_idx  = '0;
		rfree_any = 1'b0;
		rfree_idx = '0;
		for (int i = REQUEST_ENTRIES - 1; i >= 0; i--) begin
			if (r_match[i]) begin
				rhit_any = 1'b1;
				rhit_idx = RIDX_W'(i);
			end
			if (!r_valid[i]) begin
				rfree_any = 1'b1;
				rfree_idx = RIDX_W'(i);
			end
		end
	end

	assign for_us = (item_q.frame_dst_mac == MAC_BCAST) || (item_q.frame_dst_mac == own_mac_q);

	assign c_tick = '{tick: tick_go, elapsed: item_q.elapsed_ms, age_max: CACHE_AGE_MAX,
		limit: lifetime_q, expire_valid: 1'b1};
	assign r_tick = '{tick: tick_go, elapsed: item_q.elapsed_ms, age_max: REQ_AGE_MAX,
		limit: {4'b0, holdoff_q}, expire_valid: 1'b0};

	assign scan_age  = scan_cache_q ? c_age[scan_idx_q[CIDX_W-1:0]]
		: r_age[scan_idx_q[RIDX_W-1:0]];
	assign scan_last = scan_cache_q ? SIDX_W'(CACHE_ENTRIES - 1) : SIDX_W'(REQUEST_ENTRIES - 1);

	assign pend_new = '{ip: key_q, tag: item_q.datagram_tag};

	always_comb begin
		state_d      = state_q;
		emit_v       = 1'b0;
		emit_r       = '0;
		tick_go      = 1'b0;
		push         = 1'b0;
		shift        = 1'b0;
		keep_ld      = 1'b0;
		flush_drop   = 1'b0;
		flush_init   = 1'b0;
		scan_start   = 1'b0;
		scan_cache_d = 1'b0;
		scan_send_d  = 1'b0;
		c_we         = '0;
		r_we         = '0;
		c_wr         = '{ip: key_q, mac: item_q.frame_src_mac, flag: 1'b0, keep: 1'b0};
		r_wr         = '{ip: key_q, mac: '0, flag: 1'b0, keep: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				priority if (item_q.func == FN_SEND) begin
					if (chit_any) begin
						emit_v = 1'b1;
						emit_r = '{out_kind: KIND_IPV4, out_dst_mac: c_mac[chit_idx],
							out_target_ip: '0, out_tag: item_q.datagram_tag, last: 1'b0};
					end else begin
						state_d = S_SEND_Q;
					end
				end else if (item_q.func == FN_RECV) begin
					if (for_us && item_q.frame_type == ETH_ARP && item_q.arp_parse_ok
							&& item_q.arp_target_ip == own_ip_q) begin
						if (chit_any) begin
							c_we[chit_idx] = 1'b1;
							state_d = S_LEARNED;
						end else if (cfree_any) begin
							c_we[cfree_idx] = 1'b1;
							state_d = S_LEARNED;
						end else begin
							scan_start   = 1'b1;
							scan_cache_d = 1'b1;
							state_d = (CACHE_ENTRIES > 1) ? S_SCAN : S_ALLOC;
						end
					end else if (for_us && item_q.frame_type == ETH_IPV4
							&& item_q.ip_parse_ok) begin
						emit_v = 1'b1;
						emit_r = '{out_kind: KIND_DELIVER, out_dst_mac: '0,
							out_target_ip: '0, out_tag: item_q.datagram_tag, last: 1'b0};
					end
				end else if (item_q.func == FN_TICK) begin
					tick_go = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SEND_Q: begin
				if (cnt_q < CNT_W'(PENDING_DEPTH)) begin
					push = 1'b1;
				end else begin
					emit_v = 1'b1;
					emit_r = '{out_kind: KIND_DROP, out_dst_mac: '0,
						out_target_ip: '0, out_tag: item_q.datagram_tag, last: 1'b0};
				end
				state_d = (rhit_any && r_flag[rhit_idx]) ? S_FINISH : S_SEND_REQ;
			end
			S_SEND_REQ: begin
				emit_v = 1'b1;
				emit_r = '{out_kind: KIND_ARP_REQ, out_dst_mac: MAC_BCAST,
					out_target_ip: key_q, out_tag: '0, last: 1'b0};
				r_wr.flag = 1'b1;
				state_d = S_FINISH;
				if (rhit_any) begin
					r_we[rhit_idx] = 1'b1;
				end else if (rfree_any) begin
					r_we[rfree_idx] = 1'b1;
				end else begin
					scan_start  = 1'b1;
					scan_send_d = 1'b1;
					state_d = (REQUEST_ENTRIES > 1) ? S_SCAN : S_ALLOC;
				end
			end
			S_LEARNED: begin
				state_d = S_FINISH;
				if (item_q.arp_opcode == OP_REPLY) begin
					flush_init = 1'b1;
					state_d = S_FLUSH;
				end else if (item_q.arp_opcode == OP_REQUEST) begin
					emit_v = 1'b1;
					emit_r = '{out_kind: KIND_ARP_REP, out_dst_mac: item_q.frame_src_mac,
						out_target_ip: key_q, out_tag: '0, last: 1'b0};
					r_wr.keep = rhit_any;
					if (rhit_any) begin
						r_we[rhit_idx] = 1'b1;
					end else if (rfree_any) begin
						r_we[rfree_idx] = 1'b1;
					end else begin
						scan_start = 1'b1;
						state_d = (REQUEST_ENTRIES > 1) ? S_SCAN : S_ALLOC;
					end
				end
			end
			S_SCAN: begin
				if (scan_idx_q == scan_last) begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				if (scan_cache_q) begin
					c_we[best_q[CIDX_W-1:0]] = 1'b1;
					state_d = S_LEARNED;
				end else begin
					r_wr.flag = scan_send_q;
					r_we[best_q[RIDX_W-1:0]] = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FLUSH: begin
				if (rem_q == '0) begin
					state_d = S_FINISH;
				end else begin
					shift = 1'b1;
					if (pend[0].ip == key_q && sent_q < SENT_W'(MAX_FLUSH)) begin
						flush_drop = 1'b1;
						emit_v = 1'b1;
						emit_r = '{out_kind: KIND_IPV4, out_dst_mac: item_q.frame_src_mac,
							out_target_ip: '0, out_tag: pend[0].tag, last: 1'b0};
					end else begin
						keep_ld = 1'b1;
					end
				end
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			pend_load[i] = (push && cnt_q == CNT_W'(i))
				|| (keep_ld && cnt_q == CNT_W'(i + 1));
		end
	end

	for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cache
		arpr_entry_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (c_tick),
			.we     (c_we[g]),
			.wr     (c_wr),
			.key    (key_q),
			.match  (c_match[g]),
			.valid  (c_valid[g]),
			.flag   (c_flag[g]),
			.age    (c_age[g]),
			.mac    (c_mac[g])
		);
	end

	for (genvar g = 0; g < REQUEST_ENTRIES; g++) begin : g_req
		arpr_entry_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (r_tick),
			.we     (r_we[g]),
			.wr     (r_wr),
			.key    (key_q),
			.match  (r_match[g]),
			.valid  (r_valid[g]),
			.flag   (r_flag[g]),
			.age    (r_age[g]),
			.mac    (r_mac[g])
		);
	end

	for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_pend
		arpr_pend_cell u_cell (
			.clk       (clk),
			.shift     (shift),
			.next      (pend[(g + 1 < PENDING_DEPTH) ? g + 1 : g]),
			.load      (pend_load[g]),
			.load_data (keep_ld ? pend[0] : pend_new),
			.data      (pend[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			own_mac_q    <= '0;
			own_ip_q     <= '0;
			holdoff_q    <= HOLDOFF_RESET;
			lifetime_q   <= LIFETIME_RESET;
			cnt_q        <= '0;
			rem_q        <= '0;
			sent_q       <= '0;
			scan_idx_q   <= '0;
			best_q       <= '0;
			scan_cache_q <= 1'b0;
			scan_send_q  <= 1'b0;
			held_v_q     <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= held_v_q && (emit_v || state_q == S_FINISH);
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_OWN_MAC:  own_mac_q  <= cfg_data;
					CFG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
					CFG_HOLDOFF:  holdoff_q  <= cfg_data[15:0];
					CFG_LIFETIME: lifetime_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (flush_drop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (flush_init) begin
				rem_q  <= cnt_q;
				sent_q <= '0;
			end else if (shift) begin
				rem_q <= rem_q - 1'b1;
				if (flush_drop) begin
					sent_q <= sent_q + 1'b1;
				end
			end
			if (scan_start) begin
				scan_idx_q   <= SIDX_W'(1);
				best_q       <= '0;
				scan_cache_q <= scan_cache_d;
				scan_send_q  <= scan_send_d;
			end else if (state_q == S_SCAN) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_age > best_age_q) begin
					best_q <= scan_idx_q;
				end
			end
			if (emit_v) begin
				held_v_q <= 1'b1;
			end else if (state_q == S_FINISH && held_v_q) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
			key_q  <= (item.func == FN_SEND) ? item.hop_ip : item.arp_sender_ip;
		end
		if (scan_start) begin
			best_age_q <= scan_cache_d ? c_age[0] : r_age[0];
		end else if (state_q == S_SCAN && scan_age > best_age_q) begin
			best_age_q <= scan_age;
		end
		if (emit_v) begin
			held_q <= emit_r;
			if (held_v_q) begin
				result_q <= held_q;
			end
		end else if (state_q == S_FINISH && held_v_q) begin
			result_q <= '{out_kind: held_q.out_kind, out_dst_mac: held_q.out_dst_mac,
				out_target_ip: held_q.out_target_ip, out_tag: held_q.out_tag, last: 1'b1};
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

// File: verif/tb_arp_resolver_with_pending_queue.sv
// tb_arp_resolver_with_pending_queue: self-checking testbench of the arp resolver
// predicts every result from its own cache, request table and pending queue
// depends on arpr_pkg and arp_resolver_with_pending_queue
`timescale 1ns / 100ps

module tb_arp_resolver_with_pending_queue;
	import arpr_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	arpr_in_t item;
	logic result_strobe;
	arpr_out_t result;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [47:0] cfg_data;

	arp_resolver_with_pending_queue i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [47:0] m_own_mac;
	logic [31:0] m_own_ip;
	logic [15:0] m_holdoff;
	logic [19:0] m_lifetime;
	logic        c_vld [CACHE_ENTRIES];
	logic [31:0] c_ip [CACHE_ENTRIES];
	logic [47:0] c_mac [CACHE_ENTRIES];
	logic [19:0] c_age [CACHE_ENTRIES];
	logic        r_vld [REQUEST_ENTRIES];
	logic [31:0] r_ip [REQUEST_ENTRIES];
	logic [16:0] r_age [REQUEST_ENTRIES];
	logic        r_blk [REQUEST_ENTRIES];
	arpr_pend_t  pend_q[$];

	arpr_in_t  stim_q[$];
	arpr_out_t expected_q[$];
	int errors = 0;
	int n_checked = 0;
	int n_items = 0;
	int cycles = 0;
	logic drain_wait;

	logic [31:0] ip_pool [8];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_result(input logic [2:0] kind, input logic [47:0] dst,
			input logic [31:0] tip, input logic [7:0] tag, ref arpr_out_t rs[$]);
		arpr_out_t r;
		r.out_kind = kind; r.out_dst_mac = dst; r.out_target_ip = tip;
		r.out_tag = tag; r.last = 1'b0;
		if (rs.size() < MAX_FLUSH) rs = {rs, r};
	endtask

	task automatic add_stim(input arpr_in_t it);
		stim_q = {stim_q, it};
	endtask

	function automatic int cache_lookup(input logic [31:0] ip);
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (c_vld[i] && c_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic int request_lookup(input logic [31:0] ip);
		for (int i = 0; i < REQUEST_ENTRIES; i++)
			if (r_vld[i] && r_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic int request_claim(input logic [31:0] ip);
		int s;
		int best;
		s = request_lookup(ip);
		best = 0;
		if (s >= 0) return s;
		for (s = 0; s < REQUEST_ENTRIES; s++)
			if (!r_vld[s]) break;
		if (s == REQUEST_ENTRIES) begin
			for (int i = 1; i < REQUEST_ENTRIES; i++)
				if (r_age[i] > r_age[best]) best = i;
			s = best;
		end
		r_vld[s] = 1'b1; r_ip[s] = ip; r_age[s] = '0; r_blk[s] = 1'b0;
		return s;
	endfunction

	task automatic resolve_item(input arpr_in_t it);
		arpr_out_t rs[$];
		arpr_pend_t keep[$];
		arpr_pend_t p;
		int h;
		int s;
		int sent;
		logic [31:0] a;
		if (it.func == FN_SEND) begin
			h = cache_lookup(it.hop_ip);
			if (h >= 0) begin
				push_result(KIND_IPV4, c_mac[h], '0, it.datagram_tag, rs);
			end else begin
				if (pend_q.size() < PENDING_DEPTH) begin
					p.ip = it.hop_ip; p.tag = it.datagram_tag;
					pend_q = {pend_q, p};
				end else begin
					push_result(KIND_DROP, '0, '0, it.datagram_tag, rs);
				end
				s = request_lookup(it.hop_ip);
				if (!(s >= 0 && r_blk[s])) begin
					push_result(KIND_ARP_REQ, MAC_BCAST, it.hop_ip, '0, rs);
					s = request_claim(it.hop_ip);
					r_age[s] = '0; r_blk[s] = 1'b1;
				end
			end
		end else if (it.func == FN_RECV) begin
			if (it.frame_dst_mac == MAC_BCAST || it.frame_dst_mac == m_own_mac) begin
				if (it.frame_type == ETH_ARP) begin
					if (it.arp_parse_ok && it.arp_target_ip == m_own_ip) begin
						s = cache_lookup(it.arp_sender_ip);
						if (s < 0) begin
							for (s = 0; s < CACHE_ENTRIES; s++)
								if (!c_vld[s]) break;
							if (s == CACHE_ENTRIES) begin
								s = 0;
								for (int i = 1; i < CACHE_ENTRIES; i++)
									if (c_age[i] > c_age[s]) s = i;
							end
						end
						c_vld[s] = 1'b1; c_ip[s] = it.arp_sender_ip;
						c_mac[s] = it.frame_src_mac; c_age[s] = '0;
						if (it.arp_opcode == OP_REPLY) begin
							sent = 0;
							foreach (pend_q[i]) begin
								if (pend_q[i].ip == it.arp_sender_ip && sent < MAX_FLUSH) begin
									push_result(KIND_IPV4, it.frame_src_mac, '0, pend_q[i].tag, rs);
									sent++;
								end else keep = {keep, pend_q[i]};
							end
							pend_q = keep;
						end
						if (it.arp_opcode == OP_REQUEST) begin
							push_result(KIND_ARP_REP, it.frame_src_mac, it.arp_sender_ip, '0, rs);
							s = request_claim(it.arp_sender_ip);
							r_age[s] = '0;
						end
					end
				end else if (it.frame_type == ETH_IPV4) begin
					if (it.ip_parse_ok) push_result(KIND_DELIVER, '0, '0, it.datagram_tag, rs);
				end
			end
		end else if (it.func == FN_TICK) begin
			for (int i = 0; i < REQUEST_ENTRIES; i++) begin
				if (!r_vld[i]) continue;
				a = 32'(r_age[i]) + 32'(it.elapsed_ms);
				r_age[i] = (a > 32'h1FFFF) ? 17'h1FFFF : a[16:0];
				if (r_age[i] >= m_holdoff) r_blk[i] = 1'b0;
			end
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (!c_vld[i]) continue;
				a = 32'(c_age[i]) + 32'(it.elapsed_ms);
				c_age[i] = (a > 32'hFFFFF) ? 20'hFFFFF : a[19:0];
				if (c_age[i] >= m_lifetime) c_vld[i] = 1'b0;
			end
		end
		if (rs.size() > 0) rs[rs.size() - 1].last = 1'b1;
		foreach (rs[i]) expected_q = {expected_q, rs[i]};
	endtask

	// driver
	int gap = 0;
	always @(negedge clk) begin
		if (!arst_n || (drain_wait && (busy || expected_q.size() > 0))) begin
			start <= 1'b0;
		end else if (start && !busy) begin
			start <= 1'b0;
		end else if (start) begin
		end else if (gap > 0) begin
			gap <= gap - 1;
		end else if (stim_q.size() > 0) begin
			item <= stim_q.pop_front();
			start <= 1'b1;
			gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		end
	end

	// monitor
	always @(posedge clk) begin
		arpr_out_t e;
		if (arst_n && start && !busy) begin
			resolve_item(item);
			n_items++;
		end
		if (arst_n && result_strobe) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result kind %0d", result.out_kind);
				errors++;
			end else begin
				e = expected_q.pop_front();
				n_checked++;
				if (result.out_kind !== e.out_kind) begin
					$error("out_kind exp %0d got %0d", e.out_kind, result.out_kind); errors++;
				end
				if (result.out_dst_mac !== e.out_dst_mac) begin
					$error("out_dst_mac exp %h got %h", e.out_dst_mac, result.out_dst_mac);
					errors++;
				end
				if (result.out_target_ip !== e.out_target_ip) begin
					$error("out_target_ip exp %h got %h", e.out_target_ip, result.out_target_ip);
					errors++;
				end
				if (result.out_tag !== e.out_tag) begin
					$error("out_tag exp %h got %h", e.out_tag, result.out_tag); errors++;
				end
				if (result.last !== e.last) begin
					$error("last exp %b got %b", e.last, result.last); errors++;
				end
			end
		end
	end

	function automatic arpr_in_t blank_item();
		arpr_in_t it;
		it = '0;
		it.datagram_tag = 8'($urandom());
		it.elapsed_ms = 16'($urandom());
		return it;
	endfunction

	function automatic arpr_in_t send_item(input logic [31:0] ip);
		arpr_in_t it;
		it = blank_item();
		it.func = FN_SEND; it.hop_ip = ip; it.datagram_tag = 8'($urandom());
		return it;
	endfunction

	function automatic arpr_in_t arp_item(input logic [15:0] op, input logic [31:0] sip,
			input logic [47:0] src);
		arpr_in_t it;
		it = blank_item();
		it.func = FN_RECV; it.frame_type = ETH_ARP; it.arp_opcode = op;
		it.arp_sender_ip = sip; it.frame_src_mac = src; it.arp_target_ip = m_own_ip;
		it.arp_parse_ok = 1'b1;
		it.frame_dst_mac = $urandom_range(0, 1) ? MAC_BCAST : m_own_mac;
		return it;
	endfunction

	function automatic arpr_in_t tick_item(input logic [15:0] el);
		arpr_in_t it;
		it = blank_item();
		it.func = FN_TICK; it.elapsed_ms = el;
		return it;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic arpr_in_t random_item();
		arpr_in_t it;
		int k;
		logic [31:0] ip;
		ip = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
		k = $urandom_range(0, 99);
		if (k < 35) it = send_item(ip);
		else if (k < 55) it = arp_item(OP_REPLY, ip, rand48());
		else if (k < 65) it = arp_item(OP_REQUEST, ip, rand48());
		else if (k < 75)
			it = tick_item(16'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 3000)));
		else if (k < 85) begin
			it = blank_item();
			it.func = FN_RECV; it.frame_type = ETH_IPV4;
			it.frame_dst_mac = $urandom_range(0, 3) == 0 ? rand48() : m_own_mac;
			it.ip_parse_ok = $urandom_range(0, 3) != 0;
		end else begin
			// noise with every field random
			it = $bits(arpr_in_t)'({$urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom()});
			if ($urandom_range(0, 1)) it.frame_dst_mac = MAC_BCAST;
			if ($urandom_range(0, 1)) it.arp_target_ip = m_own_ip;
			if ($urandom_range(0, 1)) it.frame_type = ETH_ARP;
		end
		return it;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OWN_MAC:  m_own_mac = val;
			CFG_OWN_IP:   m_own_ip = val[31:0];
			CFG_HOLDOFF:  m_holdoff = val[15:0];
			CFG_LIFETIME: m_lifetime = val[19:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (stim_q.size() > 0 || start || busy || expected_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		arpr_in_t it;
		arst_n = 1'b0; start = 1'b0; item = '0; cfg_we = 1'b0; cfg_idx = CFG_OWN_MAC;
		cfg_data = '0;
		drain_wait = 1'b0;
		m_own_mac = '0; m_own_ip = '0; m_holdoff = HOLDOFF_RESET; m_lifetime = LIFETIME_RESET;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			c_vld[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0; c_age[i] = '0;
		end
		for (int i = 0; i < REQUEST_ENTRIES; i++) begin
			r_vld[i] = 1'b0; r_ip[i] = '0; r_age[i] = '0; r_blk[i] = 1'b0;
		end
		for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
		ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// directed part, first under reset configuration and then after register writes
		add_stim(send_item(ip_pool[0]));
		add_stim(send_item(ip_pool[0]));
		add_stim(arp_item(OP_REPLY, ip_pool[0], 48'h0));
		add_stim(send_item(ip_pool[0]));
		wait_idle();
		write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFE);
		write_reg(CFG_OWN_IP, 48'hFFFF_FFFF);
		write_reg(CFG_HOLDOFF, 48'd0);
		write_reg(CFG_LIFETIME, 48'hF_FFFF);
		for (int i = 0; i < 18; i++) add_stim(send_item(ip_pool[1]));
		add_stim(arp_item(OP_REPLY, ip_pool[1], 48'hFFFF_FFFF_FFFF));
		add_stim(arp_item(OP_REQUEST, ip_pool[2], 48'h1234_5678_9ABC));
		it = arp_item(16'd3, ip_pool[3], rand48()); add_stim(it);
		it = tick_item(16'hFFFF); add_stim(it);
		it = blank_item(); it.func = 2'd3; add_stim(it);
		it = blank_item(); it.func = FN_RECV; it.frame_type = ETH_IPV4;
		it.frame_dst_mac = m_own_mac; it.ip_parse_ok = 1'b1; it.datagram_tag = 8'hFF;
		add_stim(it);
		// sender waits for every expected result before each transfer
		drain_wait = 1'b1;
		wait_idle();
		drain_wait = 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_OWN_MAC, ph == 3 ? 48'h0 : rand48());
			write_reg(CFG_OWN_IP, 48'(ph == 3 ? 32'h0 : $urandom()));
			write_reg(CFG_HOLDOFF, 48'(ph == 1 ? 32'hFFFF : $urandom_range(0, 4000)));
			write_reg(CFG_LIFETIME, 48'(ph == 2 ? 32'h0 : $urandom_range(1000, 20000)));
			for (int i = 0; i < 33; i++) add_stim(random_item());
			wait_idle();
		end

		$display("ran %0d items, checked %0d results over six register settings",
			n_items, n_checked);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/arpr_pkg.sv
sv/arpr_entry_cell.sv
sv/arpr_pend_cell.sv
sv/arp_resolver_with_pending_queue.sv
verif/tb_arp_resolver_with_pending_queue.sv
